/* sv/lgse_pkg.sv */
// Shared constants and codes for the life grid step engine.
`default_nettype none
package lgse_pkg;
  localparam int MAX_COLS_DEF = 512;
  localparam int MAX_ROWS_DEF = 256;

  localparam int ACTION_W = 2;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int POP_W    = 18;
  localparam int GEN_W    = 32;
  localparam int GW_W     = 10;
  localparam int GH_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 10'd80;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 9'd22;

  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;
  localparam logic [POP_W-1:0] POP_MAX = '1;
endpackage
`default_nettype wire

/* sv/lgse_ifs.sv */
// Handshake channel interfaces: command in, result out, config write.
`default_nettype none
interface lgse_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lgse_pkg::ACTION_W-1:0] action;
  logic [lgse_pkg::COL_W-1:0]    col;
  logic [lgse_pkg::ROW_W-1:0]    row;
  modport source (output valid, action, col, row, input ready);
  modport sink   (input valid, action, col, row, output ready);
endinterface

interface lgse_res_if;
  logic                       valid;
  logic                       ready;
  logic                       cell_alive;
  logic [lgse_pkg::POP_W-1:0] live_count;
  logic [lgse_pkg::GEN_W-1:0] gen_count;
  modport source (output valid, cell_alive, live_count, gen_count, input ready);
  modport sink   (input valid, cell_alive, live_count, gen_count, output ready);
endinterface

interface lgse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lgse_pkg::CFG_IDX_W-1:0]  index;
  logic [lgse_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/lgse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lgse_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

/* sv/life_grid_step_engine_top.sv */
// Top level of the life grid step engine (B3/S23, dead border, ping-pong banks).
// Step and clear sweep the padded grid once before the result word; set and read
// go through the look and check states instead.
// One item at a time: in_ch.ready rises with out_ch.valid; the sweep rate is one cell
// per cycle, set by the single read port of the cell bank.
// Reset: synchronous, active low; a clearing sweep follows reset, with in_ch.ready low
// until it ends. Config writes are taken at all times.
`default_nettype none
module life_grid_step_engine_top #(
  parameter int MAX_COLS = lgse_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lgse_pkg::MAX_ROWS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lgse_cmd_if.sink    in_ch,
  lgse_res_if.source  out_ch,
  lgse_cfg_if.sink    cfg_ch
);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int AW  = CW + RW;
  localparam int QW  = AW + 1;
  localparam int C   = 1 << CW;         // line length of the padded grid
  localparam int CXW = ((CW > lgse_pkg::GW_W) ? CW : lgse_pkg::GW_W) + 1;
  localparam int RXW = ((RW > lgse_pkg::GH_W) ? RW : lgse_pkg::GH_W) + 1;
  localparam logic [QW-1:0] Q_END = QW'((1 << AW) + C);  // last read: center at N-1
  localparam logic [QW-1:0] Q_LAG = QW'(C + 1);         // read position ahead of center

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // config
  logic [lgse_pkg::GW_W-1:0] gw_r;
  logic [lgse_pkg::GH_W-1:0] gh_r;
  logic [CXW-1:0] aw_w;
  logic [RXW-1:0] ah_w;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= lgse_pkg::GRID_WIDTH_RST;
      gh_r <= lgse_pkg::GRID_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lgse_pkg::REG_GRID_WIDTH:  gw_r <= cfg_ch.data[lgse_pkg::GW_W-1:0];
        lgse_pkg::REG_GRID_HEIGHT: gh_r <= cfg_ch.data[lgse_pkg::GH_W-1:0];
        default: ;
      endcase
    end
  end

  // active region, clamped to the physical grid
  assign aw_w = (CXW'(gw_r) > CXW'(MAX_COLS)) ? CXW'(MAX_COLS) : CXW'(gw_r);
  assign ah_w = (RXW'(gh_r) > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : RXW'(gh_r);

  // counters and item registers
  logic [lgse_pkg::POP_W-1:0] pop_r, cnt_r;
  logic [lgse_pkg::GEN_W-1:0] gen_r;
  logic                       bank_r;     // bank holding the current generation
  logic                       kill_r;     // sweep writes all dead (clear / init)
  logic                       report_r;   // sweep ends with a result word
  logic [lgse_pkg::ACTION_W-1:0] act_r;
  logic [CXW-1:0]             a_col_r;
  logic [RXW-1:0]             a_row_r;
  logic                       alive_r;

  // sweep pipeline: read issue -> data/window -> write back
  logic [QW-1:0]  q_r, q1_r, q2_r;
  logic           v1_r, v2_r;
  logic [2*C-1:0] sh_r;                   // two line delays
  logic [2:0]     wl_r, wm_r, wr_r;       // window columns, bit 0 = upper row

  // RAM
  logic [AW-1:0] raddr, waddr;
  logic          we0, we1, wdata, rd0, rd1, rbit_raw;

  lgse_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_bank0 (
    .clk, .we(we0), .waddr, .wdata, .raddr, .rdata(rd0)
  );
  lgse_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_bank1 (
    .clk, .we(we1), .waddr, .wdata, .raddr, .rdata(rd1)
  );

  assign rbit_raw = bank_r ? rd1 : rd0;

  // the init sweep runs the same datapath as a clear
  logic sweeping;
  assign sweeping = (state_r == ST_SWEEP) || (state_r == ST_INIT);

  // read side
  logic rd_go, q1_in, rbit;
  assign rd_go = sweeping && (q_r <= Q_END);
  assign raddr = sweeping ? q_r[AW-1:0] : {a_row_r[RW-1:0], a_col_r[CW-1:0]};
  assign q1_in = !q1_r[AW] && (CXW'(q1_r[CW-1:0]) < aw_w)
                 && (RXW'(q1_r[AW-1:CW]) < ah_w);
  assign rbit  = rbit_raw && q1_in;

  // write side: center cell of the window
  logic [QW-1:0] ctr;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic          cvalid, c_in, mx0, mx1, my0, nxt_cell, last;
  logic [3:0]    ncnt;

  assign ctr    = q2_r - Q_LAG;
  assign cx     = ctr[CW-1:0];
  assign cy     = ctr[AW-1:CW];
  assign cvalid = sweeping && v2_r && (q2_r >= Q_LAG);
  assign last   = cvalid && (q2_r == Q_END);
  assign c_in   = (CXW'(cx) < aw_w) && (RXW'(cy) < ah_w);
  assign mx0    = (cx == '0);   // left column wraps from previous line
  assign mx1    = (cx == '1);   // right column wraps into next line
  assign my0    = (cy == '0);   // upper row is stale

  always_comb begin
    logic tl, tm, tr, ml, mr, bl, bm, br;
    tl = wl_r[0] && !mx0 && !my0;
    tm = wm_r[0] && !my0;
    tr = wr_r[0] && !mx1 && !my0;
    ml = wl_r[1] && !mx0;
    mr = wr_r[1] && !mx1;
    bl = wl_r[2] && !mx0;
    bm = wm_r[2];
    br = wr_r[2] && !mx1;
    ncnt = 4'(tl) + 4'(tm) + 4'(tr) + 4'(ml) + 4'(mr) + 4'(bl) + 4'(bm) + 4'(br);
  end

  assign nxt_cell = c_in && !kill_r &&
                    ((ncnt == lgse_pkg::BIRTH_CNT) ||
                     ((ncnt == lgse_pkg::SURVIVE_CNT) && wm_r[1]));

  // set-cell check
  logic a_in, set_wr;
  assign a_in   = (a_col_r < aw_w) && (a_row_r < ah_w);
  assign set_wr = (state_r == ST_CHK) && (act_r == lgse_pkg::ACT_SET) && a_in && !rbit_raw;

  assign waddr = cvalid ? ctr[AW-1:0] : {a_row_r[RW-1:0], a_col_r[CW-1:0]};
  assign wdata = cvalid ? nxt_cell : 1'b1;
  assign we0   = (cvalid && bank_r) || (set_wr && !bank_r);
  assign we1   = (cvalid && !bank_r) || (set_wr && bank_r);

  // handshake
  logic in_acc, out_load;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  if (last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.action) inside
            lgse_pkg::ACT_STEP, lgse_pkg::ACT_CLEAR: state_nxt = ST_SWEEP;
            default:                                  state_nxt = ST_LOOK;
          endcase
        end
      end
      ST_SWEEP: if (last) state_nxt = report_r ? ST_DONE : ST_IDLE;
      ST_LOOK:  state_nxt = ST_CHK;
      ST_CHK:   state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      bank_r   <= 1'b0;
      kill_r   <= 1'b1;
      report_r <= 1'b0;
      pop_r    <= '0;
      gen_r    <= '0;
      cnt_r    <= '0;
      q_r      <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        kill_r   <= (in_ch.action == lgse_pkg::ACT_CLEAR);
        report_r <= 1'b1;
        cnt_r    <= '0;
        q_r      <= '0;
        v1_r     <= 1'b0;
        v2_r     <= 1'b0;
      end else if (sweeping) begin
        v1_r <= rd_go;
        v2_r <= v1_r;
        if (rd_go) q_r <= q_r + 1'b1;
        if (cvalid && nxt_cell && cnt_r != lgse_pkg::POP_MAX) cnt_r <= cnt_r + 1'b1;
        if (last) begin
          bank_r <= !bank_r;
          if (kill_r) begin
            pop_r <= '0;
            gen_r <= '0;
          end else begin
            pop_r <= (nxt_cell && cnt_r != lgse_pkg::POP_MAX) ? cnt_r + 1'b1 : cnt_r;
            gen_r <= gen_r + 1'b1;
          end
        end
      end
      if (set_wr && pop_r != lgse_pkg::POP_MAX) pop_r <= pop_r + 1'b1;
      if (out_load)          out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_ch.action;
      a_col_r <= CXW'(in_ch.col);
      a_row_r <= RXW'(in_ch.row);
      alive_r <= 1'b0;
    end
    if (state_r == ST_CHK) begin
      alive_r <= (act_r == lgse_pkg::ACT_SET) ? a_in : (a_in && rbit_raw);
    end
    if (sweeping && v1_r) begin
      sh_r <= {sh_r[2*C-2:0], rbit};
      wl_r <= wm_r;
      wm_r <= wr_r;
      wr_r <= {rbit, sh_r[C-1], sh_r[2*C-1]};
    end
    if (sweeping) begin
      q1_r <= q_r;
      q2_r <= q1_r;
    end
    if (out_load) begin
      out_ch.cell_alive <= alive_r;
      out_ch.live_count <= pop_r;
      out_ch.gen_count  <= gen_r;
    end
  end

  // checks
  a_no_sweep_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(we0 || we1))
    else $error("cell bank written while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside done state");

  a_step_counts_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && last && !kill_r) |=> (gen_r == $past(gen_r) + 1'b1))
    else $error("generation not advanced by step");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> (bank_r != $past(bank_r)))
    else $error("bank not swapped at end of sweep");
endmodule
`default_nettype wire
